// ----- design/lts_pkg.sv -----
// Shared types and constants for the Levenshtein trie row step block.
// Used by lts_min_unit, lts_row_engine and levenshtein_trie_row_step.
// Depends on nothing.
`timescale 1ns / 1ps

package lts_pkg;

	// Default sizes of the query and of the trie depth.
	localparam int QUERY_MAX_DEF = 16;
	localparam int DEPTH_MAX_DEF = 64;

	// Fixed field widths.
	localparam int LEN_W   = 5;
	localparam int QIDX_W  = 4;
	localparam int CHAR_W  = 8;
	localparam int DEPTH_W = 7;
	localparam int DIST_W  = 7;
	localparam int VAL_W   = 8;

	// Edit costs, one wider than a stored row value.
	localparam logic [VAL_W:0] COST_SUB = 9'd1;
	localparam logic [VAL_W:0] COST_INS = 9'd1;
	localparam logic [VAL_W:0] COST_DEL = 9'd1;

	// Request kinds.
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_NODE = 1'b1
	} req_kind_t;

	// One request as seen by the row engine.
	typedef struct packed {
		req_kind_t           kind;
		logic [QIDX_W-1:0]   query_index;
		logic [CHAR_W-1:0]   query_char;
		logic [CHAR_W-1:0]   node_char;
		logic [DEPTH_W-1:0]  node_depth;
		logic                end_of_word;
	} lts_req_t;

	// One finished result from the row engine.
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              is_word;
	} lts_result_t;

endpackage

// ----- design/lts_min_unit.sv -----
// Compare-and-min unit for one row position, with saturation to a byte.
// Depends on lts_pkg.
`timescale 1ns / 1ps

module lts_min_unit
	import lts_pkg::*;
(
	input  logic [VAL_W-1:0] diag,
	input  logic [VAL_W-1:0] left,
	input  logic [VAL_W-1:0] up,
	input  logic             match,
	output logic [VAL_W-1:0] value
);

	logic [VAL_W:0] cost_edit;
	logic [VAL_W:0] cost_del;
	logic [VAL_W:0] cost_ins;
	logic [VAL_W:0] best;

	// Candidate costs for the three edit operations.
	assign cost_edit = {1'b0, diag} + COST_SUB;
	assign cost_del  = {1'b0, left} + COST_DEL;
	assign cost_ins  = {1'b0, up} + COST_INS;

	// Pick the diagonal on a match, otherwise the cheapest operation.
	always_comb begin
		best = cost_edit;
		if (cost_del < best) begin
			best = cost_del;
		end
		if (cost_ins < best) begin
			best = cost_ins;
		end
		if (match) begin
			best = {1'b0, diag};
		end
	end

	// Saturate at the largest byte value.
	assign value = best[VAL_W] ? {VAL_W{1'b1}} : best[VAL_W-1:0];

endmodule

// ----- design/lts_row_engine.sv -----
// Row engine: query and row memories, a read stage and a sequencer that
// walks one row position per cycle through the shared min unit.
// Depends on lts_pkg and lts_min_unit.
`timescale 1ns / 1ps

module lts_row_engine
	import lts_pkg::*;
#(
	parameter int QUERY_MAX = QUERY_MAX_DEF,
	parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_take,
	input  lts_req_t          req,
	input  logic [LEN_W-1:0]  query_len,
	output logic              busy,
	output logic              res_valid,
	input  logic              res_take,
	output lts_result_t       res
);

	localparam int ROWS  = DEPTH_MAX * QUERY_MAX;
	localparam int QW    = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
	localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int JW    = $clog2(QUERY_MAX + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CHAR_W-1:0]   query_mem [QUERY_MAX];
	logic [VAL_W-1:0]    row_mem [ROWS];

	logic [DEPTH_W-1:0]  depth_q;
	logic [CHAR_W-1:0]   char_q;
	logic                eow_q;
	logic [JW-1:0]       len_q;
	logic [RAW-1:0]      par_base_q;
	logic [RAW-1:0]      wr_base_q;
	logic [JW-1:0]       rd_j_q;
	logic [VAL_W-1:0]    left_q;
	logic [VAL_W-1:0]    diag_q;
	logic [VAL_W-1:0]    last_q;

	logic                vld_s1;
	logic [JW-1:0]       j_s1;
	logic [CHAR_W-1:0]   qchar_s1;
	logic [VAL_W-1:0]    uprow_s1;

	logic                depth_ok;
	logic                start;
	logic                load;
	logic [JW-1:0]       len_eff;
	logic                rd_more;
	logic [RAW-1:0]      rd_addr;
	logic [RAW-1:0]      wr_addr;
	logic [VAL_W-1:0]    up_val;
	logic [VAL_W-1:0]    cell_val;
	logic                cell_last;

	// Decode the accepted request.
	assign depth_ok = (req.node_depth != '0) && (32'(req.node_depth) <= DEPTH_MAX);
	assign start    = req_take && (req.kind == REQ_NODE) && depth_ok;
	assign load     = req_take && (req.kind == REQ_LOAD)
		&& (32'(req.query_index) < QUERY_MAX);

	// Clamp the query length into one through QUERY_MAX.
	always_comb begin
		if (query_len == '0) begin
			len_eff = JW'(1);
		end else if (32'(query_len) > QUERY_MAX) begin
			len_eff = JW'(QUERY_MAX);
		end else begin
			len_eff = JW'(query_len);
		end
	end

	// Addresses for the parent row read and the new row write.
	assign rd_more = (rd_j_q < len_q);
	assign rd_addr = par_base_q + RAW'(rd_j_q);
	assign wr_addr = wr_base_q + RAW'(j_s1);

	// The row above comes from memory, or from the fixed root row at depth one.
	assign up_val    = (depth_q == DEPTH_W'(1)) ? (VAL_W'(j_s1) + VAL_W'(1)) : uprow_s1;
	assign cell_last = (j_s1 == (len_q - JW'(1)));

	lts_min_unit u_min (
		.diag  (diag_q),
		.left  (left_q),
		.up    (up_val),
		.match (qchar_s1 == char_q),
		.value (cell_val)
	);

	// Query character store.
	always_ff @(posedge clk) begin
		if (load) begin
			query_mem[QW'(req.query_index)] <= req.query_char;
		end
		qchar_s1 <= query_mem[QW'(rd_j_q)];
	end

	// Row store: parent row read and new row write.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && vld_s1) begin
			row_mem[wr_addr] <= cell_val;
		end
		uprow_s1 <= row_mem[rd_addr];
	end

	// Sequencer and row registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			rd_j_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						depth_q    <= req.node_depth;
						char_q     <= req.node_char;
						eow_q      <= req.end_of_word;
						len_q      <= len_eff;
						par_base_q <= RAW'((32'(req.node_depth) - 2) * QUERY_MAX);
						wr_base_q  <= RAW'((32'(req.node_depth) - 1) * QUERY_MAX);
						left_q     <= VAL_W'(req.node_depth);
						diag_q     <= VAL_W'(req.node_depth) - VAL_W'(1);
						rd_j_q     <= '0;
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					vld_s1 <= rd_more;
					j_s1   <= rd_j_q;
					if (rd_more) begin
						rd_j_q <= rd_j_q + JW'(1);
					end
					if (vld_s1) begin
						left_q <= cell_val;
						diag_q <= up_val;
						if (cell_last) begin
							last_q  <= cell_val;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					vld_s1 <= 1'b0;
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign res_valid    = (state_q == ST_DONE);
	assign res.distance = last_q[DIST_W-1:0];
	assign res.is_word  = eow_q;

endmodule

// ----- design/levenshtein_trie_row_step.sv -----
// Levenshtein trie row step: query length register, request intake,
// output register and assertions. Depends on lts_pkg and lts_row_engine.
//
// Usage
//   Load requests (req_type 0) write one query character and leave the
//   intake free; they give no response. Node requests (req_type 1) carry a trie
//   node in depth-first order, and each one with depth 1..DEPTH_MAX gives
//   one response with the edit distance of the node's prefix to the whole
//   query and a copy of its end-of-word flag. A node with depth outside
//   that range is taken and dropped.
//   A node request walks the query one position per cycle through one
//   compare-and-min unit fed by registered query and row memory reads.
//   req_stall stays high from the intake of a node request until its result
//   is handed to the output register, so node requests never overlap.
//   When rsp_stall holds a response, the next request is still taken and
//   computed; it then waits in the engine until the output register frees.
//   Reset clears the control state and sets query_len to 1. The query and
//   row memories are not cleared; the user must see that entries are read
//   only after a write, as the block itself does not enforce it.
//   cfg_wdata is written to query_len whenever cfg_we is high.
`timescale 1ns / 1ps

module levenshtein_trie_row_step
	import lts_pkg::*;
#(
	parameter int QUERY_MAX = QUERY_MAX_DEF,
	parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               req_type,
	input  logic [QIDX_W-1:0]  query_index,
	input  logic [CHAR_W-1:0]  query_char,
	input  logic [CHAR_W-1:0]  node_char,
	input  logic [DEPTH_W-1:0] node_depth,
	input  logic               end_of_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [DIST_W-1:0]  distance,
	output logic               is_word
);

	logic [LEN_W-1:0] query_len_q;
	logic             busy;
	logic             req_take;
	lts_req_t         req;
	logic             res_valid;
	logic             res_take;
	lts_result_t      res;
	logic             rsp_valid_q;
	lts_result_t      rsp_q;

	// Query length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			query_len_q <= cfg_wdata;
		end
	end

	// Request intake.
	assign req_stall       = busy;
	assign req_take        = req_valid && !busy;
	assign req.kind        = req_kind_t'(req_type);
	assign req.query_index = query_index;
	assign req.query_char  = query_char;
	assign req.node_char   = node_char;
	assign req.node_depth  = node_depth;
	assign req.end_of_word = end_of_word;

	lts_row_engine #(
		.QUERY_MAX (QUERY_MAX),
		.DEPTH_MAX (DEPTH_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_take  (req_take),
		.req       (req),
		.query_len (query_len_q),
		.busy      (busy),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// Output register, loaded when empty or being drained.
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign distance  = rsp_q.distance;
	assign is_word   = rsp_q.is_word;

`ifndef SYNTHESIS
	// A node request of depth one occupies the engine on the next cycle.
	a_node_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req_type == REQ_NODE) && (node_depth == DEPTH_W'(1))
		|=> req_stall)
		else $error("node request did not occupy the engine");

	// A load request leaves the block free for the next cycle.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req_type == REQ_LOAD) |=> !req_stall)
		else $error("load request stalled the block");

	// A finished result waiting for the output register does not change.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid && $stable(res))
		else $error("pending result changed before it was taken");

	// A result is only handed over while a request is in progress.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> req_stall)
		else $error("result pending while requests are taken");
`endif

endmodule

// ----- sim/tb_levenshtein_trie_row_step.sv -----
// Self-checking testbench for levenshtein_trie_row_step: trie walks against a model of the rows.
// Depends on lts_pkg and the levenshtein_trie_row_step design files; reads no input files.
`timescale 1ns / 1ps

module tb_levenshtein_trie_row_step;
	import lts_pkg::*;

	localparam int QUERY_MAX   = QUERY_MAX_DEF;
	localparam int DEPTH_MAX   = DEPTH_MAX_DEF;
	localparam int DRAIN       = 2 * QUERY_MAX + 8;
	localparam int CYCLE_LIMIT = 600000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [LEN_W-1:0]   cfg_wdata;
	logic               req_valid;
	logic               req_stall;
	logic               req_type;
	logic [QIDX_W-1:0]  query_index;
	logic [CHAR_W-1:0]  query_char;
	logic [CHAR_W-1:0]  node_char;
	logic [DEPTH_W-1:0] node_depth;
	logic               end_of_word;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [DIST_W-1:0]  distance;
	logic               is_word;

	// Model state: query characters, stored rows and the query length register.
	logic [CHAR_W-1:0] query_mem [QUERY_MAX];
	logic [VAL_W-1:0]  row_mem [DEPTH_MAX][QUERY_MAX];
	int                row_written [DEPTH_MAX];
	logic [LEN_W-1:0]  query_len_reg;

	lts_result_t pending_scores [$];
	lts_result_t oldest_score;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;
	int          stall_left = 0;

	levenshtein_trie_row_step i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.query_index (query_index),
		.query_char  (query_char),
		.node_char   (node_char),
		.node_depth  (node_depth),
		.end_of_word (end_of_word),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.distance    (distance),
		.is_word     (is_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Idle stretches are mostly short, sometimes long.
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(2, 1);
		else if (r < 90)
			return $urandom_range(8, 3);
		return $urandom_range(60, 20);
	endfunction

	// Query length as the block uses it: zero acts as one, large values clip.
	function automatic int live_len();
		if (query_len_reg == 0)
			return 1;
		if (query_len_reg > QUERY_MAX)
			return QUERY_MAX;
		return query_len_reg;
	endfunction

	// A node may only be scored once its whole parent row has been written.
	function automatic bit parent_ready(int depth);
		return depth == 1 || row_written[depth-2] >= live_len();
	endfunction

	function automatic logic [CHAR_W-1:0] pick_letter(bit narrow);
		if (narrow)
			return 8'h61 + CHAR_W'($urandom_range(3));
		return CHAR_W'($urandom_range(255));
	endfunction

	// Applies one accepted request to the model and queues the expected score.
	function automatic void score_request(lts_req_t r);
		int depth, n, left, diag, up, v, last;
		lts_result_t res;
		if (r.kind == REQ_LOAD) begin
			query_mem[r.query_index] = r.query_char;
			return;
		end
		depth = r.node_depth;
		if (depth == 0 || depth > DEPTH_MAX)
			return;
		n = live_len();
		left = depth;
		diag = depth - 1;
		last = 0;
		for (int j = 0; j < n; j++) begin
			up = (depth == 1) ? j + 1 : row_mem[depth-2][j];
			if (query_mem[j] == r.node_char)
				v = diag;
			else begin
				v = diag + COST_SUB;
				if (left + COST_DEL < v)
					v = left + COST_DEL;
				if (up + COST_INS < v)
					v = up + COST_INS;
			end
			if (v > 255)
				v = 255;
			row_mem[depth-1][j] = VAL_W'(v);
			left = v;
			diag = up;
			last = v;
		end
		if (row_written[depth-1] < n)
			row_written[depth-1] = n;
		res.distance = DIST_W'(last);
		res.is_word = r.end_of_word;
		pending_scores.push_back(res);
	endfunction

	// Drives one request from a falling edge and returns at the falling edge after acceptance.
	task automatic send_request(lts_req_t r);
		int gap;
		gap = (!calm && $urandom_range(99) < 30) ? pick_idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type    <= r.kind;
		query_index <= r.query_index;
		query_char  <= r.query_char;
		node_char   <= r.node_char;
		node_depth  <= r.node_depth;
		end_of_word <= r.end_of_word;
		req_valid   <= 1'b1;
		do @(posedge clk); while (req_stall);
		score_request(r);
		@(negedge clk);
	endtask

	// Unused fields carry random values so that every input bit toggles.
	task automatic send_load(int idx, logic [CHAR_W-1:0] ch);
		lts_req_t r;
		r = lts_req_t'({$urandom, $urandom});
		r.kind = REQ_LOAD;
		r.query_index = QIDX_W'(idx);
		r.query_char = ch;
		send_request(r);
	endtask

	task automatic send_node(logic [CHAR_W-1:0] ch, int depth, logic eow);
		lts_req_t r;
		r = lts_req_t'({$urandom, $urandom});
		r.kind = REQ_NODE;
		r.node_char = ch;
		r.node_depth = DEPTH_W'(depth);
		r.end_of_word = eow;
		send_request(r);
	endtask

	// Holds off new requests until every queued score has come back.
	task automatic wait_results();
		req_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(negedge clk);
	endtask

	// Idle point: no scores pending, and time for a load or dropped node to finish.
	task automatic quiesce();
		wait_results();
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_query_len(logic [LEN_W-1:0] len);
		quiesce();
		cfg_wdata <= len;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		query_len_reg = len;
	endtask

	task automatic load_query_word(bit narrow);
		for (int i = 0; i < QUERY_MAX; i++)
			send_load(i, pick_letter(narrow));
	endtask

	// Depth-first walk: mostly children and siblings, some backtracking, plus noise
	// in the form of query reloads and nodes with an illegal depth.
	task automatic walk_trie(int steps, bit narrow);
		int last_depth, depth, pick;
		logic [CHAR_W-1:0] ch;
		last_depth = 0;
		repeat (steps) begin
			if ($urandom_range(199) == 0)
				wait_results();
			pick = $urandom_range(99);
			if (pick < 8)
				send_load($urandom_range(QUERY_MAX - 1), pick_letter(narrow));
			else if (pick < 11) begin
				depth = $urandom_range(1) ? 0 : $urandom_range(127, DEPTH_MAX + 1);
				send_node(pick_letter(narrow), depth, $urandom_range(1));
			end else begin
				pick = $urandom_range(99);
				if (pick < 55 || last_depth == 0)
					depth = last_depth + 1;
				else if (pick < 80)
					depth = last_depth;
				else
					depth = $urandom_range(last_depth, 1);
				if (depth > DEPTH_MAX)
					depth = DEPTH_MAX;
				if (!parent_ready(depth))
					depth = 1;
				if ($urandom_range(99) < 65)
					ch = query_mem[$urandom_range(live_len() - 1)];
				else
					ch = pick_letter(narrow);
				send_node(ch, depth, $urandom_range(1));
				last_depth = depth;
			end
		end
	endtask

	// Single-character query, byte extremes, illegal depths and a zero length.
	task automatic test_directed_corners();
		calm = 1'b1;
		send_load(0, 8'h00);
		send_node(8'h00, 1, 1'b1);
		send_node(8'hFF, 1, 1'b0);
		send_node(8'h00, 2, 1'b1);
		send_node(8'h00, 0, 1'b1);
		send_node(8'hFF, DEPTH_MAX + 1, 1'b0);
		send_node(8'hFF, 127, 1'b1);
		send_load(QUERY_MAX - 1, 8'hFF);
		send_load(0, 8'hFF);
		send_node(8'hFF, 3, 1'b1);
		send_node(8'h80, 2, 1'b0);
		write_query_len(5'd0);
		send_node(8'hFF, 1, 1'b0);
		send_node(8'h01, 2, 1'b1);
		send_node(8'hFF, 3, 1'b0);
	endtask

	// Random walks under a range of query lengths, including both register extremes.
	task automatic test_length_sweep();
		int sweep_lens [10] = '{16, 31, 2, 17, 7, 1, 12, 0, 30, 5};
		bit narrow;
		for (int p = 0; p < 10; p++) begin
			write_query_len(LEN_W'(sweep_lens[p]));
			calm = (p % 3 == 1);
			narrow = (p % 2 == 0);
			load_query_word(narrow);
			walk_trie(90, narrow);
		end
	endtask

	// One branch straight down to the deepest row with a full-length query.
	task automatic test_deep_branch();
		logic [CHAR_W-1:0] ch;
		write_query_len(5'd16);
		calm = 1'b0;
		load_query_word(1'b0);
		for (int d = 1; d <= DEPTH_MAX; d++) begin
			ch = ($urandom_range(1)) ? query_mem[$urandom_range(QUERY_MAX - 1)]
			                         : pick_letter(1'b0);
			send_node(ch, d, $urandom_range(1));
		end
		send_node(pick_letter(1'b0), DEPTH_MAX, 1'b1);
	endtask

	// Response side: random stall stretches unless the phase is calm.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (!calm && $urandom_range(99) < 25)
					stall_left = pick_idle_len();
			end
		end
	end

	// Compare every accepted response with the oldest queued score.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_scores.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual distance %0d is_word %0b",
					$time, distance, is_word);
				mismatch_count++;
			end else begin
				oldest_score = pending_scores.pop_front();
				if (distance !== oldest_score.distance) begin
					$display("%0t: distance mismatch: expected %0d, actual %0d",
						$time, oldest_score.distance, distance);
					mismatch_count++;
				end
				if (is_word !== oldest_score.is_word) begin
					$display("%0t: is_word mismatch: expected %0b, actual %0b",
						$time, oldest_score.is_word, is_word);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		req_valid   = 1'b0;
		req_type    = REQ_LOAD;
		query_index = '0;
		query_char  = '0;
		node_char   = '0;
		node_depth  = '0;
		end_of_word = 1'b0;
		query_len_reg = 5'd1;
		foreach (row_written[i])
			row_written[i] = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_corners();
		test_length_sweep();
		test_deep_branch();
		quiesce();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
design/lts_pkg.sv
design/lts_min_unit.sv
design/lts_row_engine.sv
design/levenshtein_trie_row_step.sv
sim/tb_levenshtein_trie_row_step.sv
